/* hw/rtl/tlca_pkg.sv */
// Package for the binary-lifting common-ancestor engine.
// Holds the command codes and the item and table-entry structs.
// No dependencies.
package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic               has_parent;
    logic [DEPTH_W-1:0] node_depth;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] common_ancestor;
    logic              error;
  } out_item_t;

  typedef struct packed {
    logic              present;
    logic [NODE_W-1:0] node;
  } anc_entry_t;

  localparam int ANC_W = $bits(anc_entry_t);

endpackage

/* hw/rtl/tlca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tree_lca_distance_query.sv */
// Top level of the binary-lifting common-ancestor and path-length engine.
// Depends on tlca_pkg and tlca_ram (depth store and ancestor table).
//
// Usage: set node_count through cfg_we/cfg_wdata while idle (reset value 1).
// Issue a transaction by raising start with in_item while busy is low.
// A load transaction writes one node's depth and parent in the accept cycle
// and leaves busy low. A build transaction fills levels 1..LOG_MAX of the
// ancestor table through S_B0, S_B1 and, if the entry is present, S_B2 for
// each node at each level, driven by one sequencer over the single table
// read port. A query returns one result on out_item, marked by a one-cycle
// out_strobe; the receiver cannot stall it. A rejected node answers in the
// cycle after the accept; otherwise the query reads both depths, lifts the
// deeper node (lifting steps at most the popcount of the depth gap), and if
// it does not meet the other, lifts both in parallel over the shared read
// port and reads the parent. busy falls in the cycle that carries out_strobe.
// Reset idles the sequencer, clears the strobe and sets node_count to 1; the depth store and
// ancestor table are not cleared and must be loaded and built before use.
module tree_lca_distance_query #(
  parameter int MAX_NODES = 1024,
  parameter int LOG_MAX   = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  tlca_pkg::in_item_t                 in_item,
  output logic                               out_strobe,
  output tlca_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [tlca_pkg::NODE_W-1:0]        cfg_wdata
);
  import tlca_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(LOG_MAX + 1);
  localparam int AW = NW + LW;
  localparam int ANC_DEPTH = MAX_NODES << LW;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_QDA   = 15'b000000000000010,
    S_QDB   = 15'b000000000000100,
    S_QSW   = 15'b000000000001000,
    S_LIFT  = 15'b000000000010000,
    S_LIFTW = 15'b000000000100000,
    S_PA    = 15'b000000001000000,
    S_PB    = 15'b000000010000000,
    S_PC    = 15'b000000100000000,
    S_FA    = 15'b000001000000000,
    S_FW    = 15'b000010000000000,
    S_FD    = 15'b000100000000000,
    S_B0    = 15'b001000000000000,
    S_B1    = 15'b010000000000000,
    S_B2    = 15'b100000000000000
  } state_t;

  function automatic int top_bit(input logic [DEPTH_W-1:0] v);
    int r;
    r = 0;
    for (int i = 0; i < DEPTH_W; i++) begin
      if (v[i]) begin
        r = i;
      end
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   node_count_r, node_count_nxt;
  logic [NODE_W-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [DEPTH_W-1:0]  da_r, da_nxt;
  logic [DEPTH_W-1:0]  diff_r, diff_nxt;
  logic [DIST_W-1:0]   sum_r, sum_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  anc_entry_t          ea_r, ea_nxt;
  logic [NODE_W-1:0]   lca_r, lca_nxt;
  logic                found_r, found_nxt;
  logic [NODE_W-1:0]   j_r, j_nxt, last_r, last_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                accept;
  logic                a_bad, b_bad, q_bad;
  logic [NODE_W-1:0]   last_calc;
  logic [LW-1:0]       lift_lvl;
  logic                build_last_j;
  logic [DIST_W-1:0]   two_dl;

  logic                dep_we;
  logic [NW-1:0]       dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0]  dep_wdata, dep_rdata;
  logic                anc_we;
  logic [AW-1:0]       anc_waddr, anc_raddr;
  anc_entry_t          anc_wdata, anc_rdata;
  logic [ANC_W-1:0]    anc_rdata_raw;

  tlca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  tlca_ram #(.WIDTH(ANC_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata_raw)
  );

  assign anc_rdata = anc_entry_t'(anc_rdata_raw);

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign a_bad = (in_item.node_a == '0) || (in_item.node_a > node_count_r) ||
                 (32'(in_item.node_a) >= MAX_NODES);
  assign b_bad = (in_item.node_b == '0) || (in_item.node_b > node_count_r) ||
                 (32'(in_item.node_b) >= MAX_NODES);
  assign q_bad = a_bad || b_bad;

  assign last_calc = (32'(node_count_r) > MAX_NODES - 1) ?
                     NODE_W'(MAX_NODES - 1) : node_count_r;
  assign lift_lvl  = (top_bit(diff_r) > LOG_MAX) ? LW'(LOG_MAX) : LW'(top_bit(diff_r));
  assign build_last_j = (j_r == last_r);
  assign two_dl = found_r ? {dep_rdata, 1'b0} : '0;

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = cfg_we ? cfg_wdata : node_count_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    da_nxt         = da_r;
    diff_nxt       = diff_r;
    sum_nxt        = sum_r;
    lvl_nxt        = lvl_r;
    ea_nxt         = ea_r;
    lca_nxt        = lca_r;
    found_nxt      = found_r;
    j_nxt          = j_r;
    last_nxt       = last_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;

    dep_we    = 1'b0;
    dep_waddr = NW'(in_item.node_a);
    dep_wdata = in_item.node_depth;
    dep_raddr = NW'(a_r);
    anc_we    = 1'b0;
    anc_waddr = {NW'(in_item.node_a), LW'(0)};
    anc_wdata = '0;
    anc_raddr = {NW'(a_r), lvl_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.command)
            CMD_LOAD: begin
              if (32'(in_item.node_a) < MAX_NODES) begin
                dep_we = 1'b1;
                anc_we = 1'b1;
                if (in_item.has_parent && (32'(in_item.node_b) < MAX_NODES)) begin
                  anc_wdata = '{present: 1'b1, node: in_item.node_b};
                end
              end
            end
            CMD_BUILD: begin
              last_nxt = last_calc;
              j_nxt    = NODE_W'(1);
              lvl_nxt  = LW'(1);
              if (last_calc != '0) begin
                state_nxt = S_B0;
              end
            end
            CMD_QUERY: begin
              a_nxt = in_item.node_a;
              b_nxt = in_item.node_b;
              if (q_bad) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '{distance: '0, common_ancestor: '0, error: 1'b1};
              end else begin
                state_nxt = S_QDA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_QDA: begin
        dep_raddr = NW'(a_r);
        state_nxt = S_QDB;
      end
      S_QDB: begin
        da_nxt    = dep_rdata;
        dep_raddr = NW'(b_r);
        state_nxt = S_QSW;
      end
      S_QSW: begin
        sum_nxt = DIST_W'(da_r) + DIST_W'(dep_rdata);
        if (dep_rdata < da_r) begin
          a_nxt    = b_r;
          b_nxt    = a_r;
          diff_nxt = da_r - dep_rdata;
        end else begin
          diff_nxt = dep_rdata - da_r;
        end
        state_nxt = S_LIFT;
      end
      S_LIFT: begin
        if (diff_r == '0) begin
          if (a_r == b_r) begin
            lca_nxt   = a_r;
            found_nxt = 1'b1;
            dep_raddr = NW'(a_r);
            state_nxt = S_FD;
          end else begin
            lvl_nxt   = LW'(LOG_MAX);
            state_nxt = S_PA;
          end
        end else begin
          lvl_nxt   = lift_lvl;
          anc_raddr = {NW'(b_r), lift_lvl};
          state_nxt = S_LIFTW;
        end
      end
      S_LIFTW: begin
        if (anc_rdata.present) begin
          b_nxt    = anc_rdata.node;
          diff_nxt = diff_r - (DEPTH_W'(1) << lvl_r);
        end else begin
          diff_nxt = '0;
        end
        state_nxt = S_LIFT;
      end
      S_PA: begin
        anc_raddr = {NW'(a_r), lvl_r};
        state_nxt = S_PB;
      end
      S_PB: begin
        ea_nxt    = anc_rdata;
        anc_raddr = {NW'(b_r), lvl_r};
        state_nxt = S_PC;
      end
      S_PC: begin
        if (ea_r.present && anc_rdata.present && (ea_r.node != anc_rdata.node)) begin
          a_nxt = ea_r.node;
          b_nxt = anc_rdata.node;
        end
        if (lvl_r == '0) begin
          state_nxt = S_FA;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_PA;
        end
      end
      S_FA: begin
        anc_raddr = {NW'(a_r), LW'(0)};
        state_nxt = S_FW;
      end
      S_FW: begin
        found_nxt = anc_rdata.present;
        lca_nxt   = anc_rdata.present ? anc_rdata.node : '0;
        dep_raddr = NW'(anc_rdata.node);
        state_nxt = S_FD;
      end
      S_FD: begin
        out_strobe_nxt               = 1'b1;
        out_item_nxt.error           = 1'b0;
        out_item_nxt.common_ancestor = lca_r;
        out_item_nxt.distance        = (two_dl > sum_r) ? '0 : (sum_r - two_dl);
        state_nxt                    = S_IDLE;
      end
      S_B0: begin
        anc_raddr = {NW'(j_r), lvl_r - LW'(1)};
        state_nxt = S_B1;
      end
      S_B1, S_B2: begin
        anc_waddr = {NW'(j_r), lvl_r};
        if ((state_r == S_B1) && anc_rdata.present) begin
          anc_raddr = {NW'(anc_rdata.node), lvl_r - LW'(1)};
          state_nxt = S_B2;
        end else begin
          anc_we    = 1'b1;
          anc_wdata = (state_r == S_B2) ? anc_rdata : '0;
          if (build_last_j) begin
            j_nxt = NODE_W'(1);
            if (lvl_r == LW'(LOG_MAX)) begin
              state_nxt = S_IDLE;
            end else begin
              lvl_nxt   = lvl_r + LW'(1);
              state_nxt = S_B0;
            end
          end else begin
            j_nxt     = j_r + NODE_W'(1);
            state_nxt = S_B0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_W'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    da_r       <= da_nxt;
    diff_r     <= diff_nxt;
    sum_r      <= sum_nxt;
    lvl_r      <= lvl_nxt;
    ea_r       <= ea_nxt;
    lca_r      <= lca_nxt;
    found_r    <= found_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    out_item_r <= out_item_nxt;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while sequencer busy");

  a_bad_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.command == CMD_QUERY) && q_bad) |=> (out_strobe && out_item.error))
    else $error("rejected query gave no error result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.error) |-> (out_item.distance == '0 &&
                                       out_item.common_ancestor == '0))
    else $error("error result carries nonzero payload");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.command != CMD_QUERY)) |=> !out_strobe)
    else $error("result strobe after non-query transaction");

  a_parallel_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PC && lvl_r == '0) |=> (state_r == S_FA))
    else $error("parallel lift did not finish at level zero");

endmodule

/* sim/tlca_answer_checker.sv */
// Answer checker for the common-ancestor engine: mirrors the depth store and jump table,
// predicts each query answer and compares it with the strobed result.
// Depends on tlca_pkg.
module tlca_answer_checker #(
  parameter int MAX_NODES = 1024,
  parameter int LOG_MAX   = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  tlca_pkg::in_item_t          in_item,
  input  logic                        out_strobe,
  input  tlca_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);
  import tlca_pkg::*;

  int                 nodes_covered;
  logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
  anc_entry_t         jump_tbl [MAX_NODES][LOG_MAX+1];
  out_item_t          answers_due [$];

  function automatic bit node_rejected(int v);
    return v == 0 || v > nodes_covered || v >= MAX_NODES;
  endfunction

  function automatic int highest_bit(int v);
    int i = 0;
    while (v > 1) begin
      v = v >> 1;
      i++;
    end
    return i;
  endfunction

  function automatic void store_node(int v, int p, bit hp, int d);
    if (v < MAX_NODES) begin
      depth_mem[v] = d[DEPTH_W-1:0];
      if (hp && p < MAX_NODES) begin
        jump_tbl[v][0].present = 1'b1;
        jump_tbl[v][0].node = p[NODE_W-1:0];
      end else begin
        jump_tbl[v][0] = '0;
      end
    end
  endfunction

  function automatic void fill_jump_levels();
    int last;
    anc_entry_t e;
    last = nodes_covered;
    if (last > MAX_NODES - 1) last = MAX_NODES - 1;
    for (int k = 1; k <= LOG_MAX; k++) begin
      for (int j = 1; j <= last; j++) begin
        e = jump_tbl[j][k-1];
        jump_tbl[j][k] = e.present ? jump_tbl[e.node][k-1] : '0;
      end
    end
  endfunction

  function automatic out_item_t answer_query(int a, int b);
    out_item_t  r;
    int         x, y, t, gap, lvl, lca, path_len;
    bit         found;
    anc_entry_t ex, ey;
    r = '0;
    if (node_rejected(a) || node_rejected(b)) begin
      r.error = 1'b1;
      return r;
    end
    x = a;
    y = b;
    if (depth_mem[y] < depth_mem[x]) begin
      t = x;
      x = y;
      y = t;
    end
    gap = int'(depth_mem[y]) - int'(depth_mem[x]);
    while (gap > 0) begin
      lvl = highest_bit(gap);
      if (lvl > LOG_MAX) lvl = LOG_MAX;
      ey = jump_tbl[y][lvl];
      if (!ey.present) break;
      y = ey.node;
      gap = gap - (1 << lvl);
    end
    found = 1'b1;
    if (x == y) begin
      lca = x;
    end else begin
      for (int k = LOG_MAX; k >= 0; k--) begin
        ex = jump_tbl[x][k];
        ey = jump_tbl[y][k];
        if (ex.present && ey.present && ex.node != ey.node) begin
          x = ex.node;
          y = ey.node;
        end
      end
      found = jump_tbl[x][0].present;
      lca = found ? int'(jump_tbl[x][0].node) : 0;
    end
    path_len = int'(depth_mem[a]) + int'(depth_mem[b]) -
               (found ? 2 * int'(depth_mem[lca]) : 0);
    if (path_len < 0) path_len = 0;
    r.distance = path_len[DIST_W-1:0];
    r.common_ancestor = lca[NODE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      nodes_covered = 1;
      answers_due.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (out_strobe) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer: distance %0d ancestor %0d error %0b",
                   $time, out_item.distance, out_item.common_ancestor, out_item.error);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          checked <= checked + 1;
          if (out_item.distance !== want.distance ||
              out_item.common_ancestor !== want.common_ancestor ||
              out_item.error !== want.error) begin
            $display("%0t: expected distance %0d ancestor %0d error %0b, got %0d %0d %0b",
                     $time, want.distance, want.common_ancestor, want.error,
                     out_item.distance, out_item.common_ancestor, out_item.error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) nodes_covered = int'(cfg_wdata);
      if (start && !busy) begin
        case (in_item.command)
          CMD_LOAD: store_node(in_item.node_a, in_item.node_b, in_item.has_parent,
                               in_item.node_depth);
          CMD_BUILD: fill_jump_levels();
          CMD_QUERY: answers_due = {answers_due,
                                    answer_query(in_item.node_a, in_item.node_b)};
          default: ;
        endcase
      end
    end
    pending <= answers_due.size();
  end

endmodule

/* sim/tb_tree_lca_distance_query.sv */
// Testbench top for tree_lca_distance_query: loads random trees, builds the jump table
// and issues distance queries under varying idle patterns; tlca_answer_checker judges answers.
// Depends on tlca_pkg, tree_lca_distance_query and tlca_answer_checker.
module tb_tree_lca_distance_query;
  import tlca_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TOP_NODE    = (1 << NODE_W) - 1;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_DEEP,
    SHAPE_STAR,
    SHAPE_FOREST,
    SHAPE_SKEWED
  } tree_shape_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_strobe;
  out_item_t          out_item;
  logic               cfg_we;
  logic [NODE_W-1:0]  cfg_wdata;

  int fail_count, pending, checked;
  int cycles = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int sessions = 0;

  tree_lca_distance_query u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  tlca_answer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(cmd_t c, int a, int b, bit hp, int d);
    in_item_t it;
    it.command = c;
    it.node_a = a[NODE_W-1:0];
    it.node_b = b[NODE_W-1:0];
    it.has_parent = hp;
    it.node_depth = d[DEPTH_W-1:0];
    return it;
  endfunction

  task automatic issue(in_item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    case ((items_sent / 64) % 4)
      1: idle_pct = 82;
      3: idle_pct = 31;
      default: idle_pct = 0;
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    repeat (4) @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_node_count(int n);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= n[NODE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_cases();
    issue(make_item(CMD_LOAD, 1, 0, 1'b0, 0));
    issue(make_item(CMD_BUILD, 0, 0, 1'b0, 0));
    issue(make_item(CMD_QUERY, 1, 1, 1'b0, 0));
    issue(make_item(CMD_QUERY, 0, 1, 1'b0, 0));
    issue(make_item(CMD_QUERY, 1, 0, 1'b0, 0));
    issue(make_item(CMD_QUERY, 1, 2, 1'b0, 0));
    issue(make_item(CMD_QUERY, TOP_NODE, TOP_NODE, 1'b1, TOP_NODE));
    issue(make_item(CMD_NONE, TOP_NODE, TOP_NODE, 1'b1, TOP_NODE));
    issue(make_item(CMD_LOAD, 0, TOP_NODE, 1'b1, TOP_NODE));
    set_node_count(3);
    issue(make_item(CMD_LOAD, 1, TOP_NODE, 1'b0, TOP_NODE));
    issue(make_item(CMD_LOAD, 2, 0, 1'b0, TOP_NODE));
    issue(make_item(CMD_LOAD, 3, 1, 1'b1, 0));
    issue(make_item(CMD_BUILD, TOP_NODE, TOP_NODE, 1'b1, TOP_NODE));
    issue(make_item(CMD_QUERY, 1, 2, 1'b0, 0));
    issue(make_item(CMD_QUERY, 3, 1, 1'b0, 0));
    issue(make_item(CMD_QUERY, 2, 3, 1'b0, 0));
    issue(make_item(CMD_QUERY, 3, 3, 1'b0, 0));
    set_node_count(2);
    issue(make_item(CMD_QUERY, 3, 1, 1'b0, 0));
    issue(make_item(CMD_QUERY, 2, 1, 1'b0, 0));
  endtask

  task automatic run_tree(int n, tree_shape_t shape, int queries);
    int dep [1 << NODE_W];
    int p, a, b, r, hub;
    bit hp;
    sessions++;
    set_node_count(n);
    for (int v = 1; v <= n; v++) begin
      hp = !(v == 1 || (shape == SHAPE_FOREST && $urandom_range(9) == 0));
      if (!hp) begin
        p = $urandom_range(TOP_NODE);
        dep[v] = (shape == SHAPE_SKEWED) ? $urandom_range(TOP_NODE) : 0;
      end else begin
        hub = (v - 1 < 3) ? v - 1 : 3;
        case (shape)
          SHAPE_DEEP: p = ($urandom_range(9) < 7) ? v - 1 : $urandom_range(v - 1, 1);
          SHAPE_STAR: p = $urandom_range(hub, 1);
          default:    p = $urandom_range(v - 1, 1);
        endcase
        dep[v] = (shape == SHAPE_SKEWED) ? $urandom_range(TOP_NODE) : dep[p] + 1;
      end
      issue(make_item(CMD_LOAD, v, p, hp, dep[v]));
    end
    issue(make_item(CMD_BUILD, $urandom_range(TOP_NODE), 0, 1'b0, 0));
    for (int q = 0; q < queries; q++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        a = $urandom_range(n, 1);
        b = ($urandom_range(9) == 0) ? a : $urandom_range(n, 1);
        issue(make_item(CMD_QUERY, a, b, $urandom_range(1), $urandom_range(TOP_NODE)));
      end else if (r < 88) begin
        case ($urandom_range(2))
          0: a = 0;
          1: a = (n < TOP_NODE) ? $urandom_range(TOP_NODE, n + 1) : 0;
          default: a = $urandom_range(TOP_NODE);
        endcase
        b = $urandom_range(n, 1);
        if ($urandom_range(1)) issue(make_item(CMD_QUERY, a, b, 1'b0, 0));
        else issue(make_item(CMD_QUERY, b, a, 1'b0, 0));
      end else if (r < 92) begin
        issue(make_item(CMD_NONE, $urandom_range(TOP_NODE), $urandom_range(TOP_NODE),
                        $urandom_range(1), $urandom_range(TOP_NODE)));
      end else if (r < 96) begin
        a = (n < TOP_NODE) ? $urandom_range(TOP_NODE, n + 1) : 0;
        issue(make_item(CMD_LOAD, a, $urandom_range(TOP_NODE), $urandom_range(1),
                        $urandom_range(TOP_NODE)));
      end else if (r < 99) begin
        issue(make_item(CMD_LOAD, $urandom_range(n, 1), $urandom_range(n, 1),
                        $urandom_range(1), $urandom_range(TOP_NODE)));
      end else begin
        issue(make_item(CMD_BUILD, 0, 0, 1'b0, 0));
      end
    end
  endtask

  initial begin : stimulus
    int n, r;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_cases();
    run_tree(TOP_NODE, SHAPE_DEEP, 100);
    run_tree(1, SHAPE_RANDOM, 10);
    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(9);
      if (r < 2) n = $urandom_range(4, 1);
      else if (r < 8) n = $urandom_range(24, 5);
      else n = $urandom_range(80, 25);
      run_tree(n, tree_shape_t'($urandom_range(4)), $urandom_range(40, 15));
    end
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (64) @(posedge clk);
    $display("Issued %0d transactions over %0d tree setups, node_count from 1 to %0d.",
             items_sent, sessions, TOP_NODE);
    $display("Compared %0d query answers under steady and bursty input pacing.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
